// ===== rtl/core/vtpt_pkg.sv =====
// Shared types and constants of the vertex timing pile-up tagger.
package vtpt_pkg;

    localparam int TAG_BITS = 4;

    localparam logic [1:0] ACT_START    = 2'd0;
    localparam logic [1:0] ACT_VERTEX   = 2'd1;
    localparam logic [1:0] ACT_PARTICLE = 2'd2;

    localparam logic [1:0] CFG_CHARGED_LIMIT = 2'd0;
    localparam logic [1:0] CFG_NEUTRAL_LIMIT = 2'd1;
    localparam logic [1:0] CFG_PT_MINIMUM    = 2'd2;

    localparam logic [9:0]  RST_CHARGED_LIMIT = 10'd48;
    localparam logic [9:0]  RST_NEUTRAL_LIMIT = 10'd48;
    localparam logic [15:0] RST_PT_MINIMUM    = 16'd0;

    typedef enum logic [3:0] {
        STEP_DZ2 = 4'd0,
        STEP_DT2 = 4'd1,
        STEP_EZ2 = 4'd2,
        STEP_ET2 = 4'd3,
        STEP_LC2 = 4'd4,
        STEP_LN2 = 4'd5,
        STEP_P1  = 4'd6,
        STEP_P2  = 4'd7,
        STEP_E   = 4'd8,
        STEP_Q0  = 4'd9,
        STEP_Q1  = 4'd10,
        STEP_NR  = 4'd11
    } t_step;

    typedef struct packed {
        logic [1:0]          action;
        logic [31:0]         sum_pt_sq;
        logic signed [15:0]  pos_z;
        logic [15:0]         pos_z_err;
        logic signed [15:0]  pos_t;
        logic [15:0]         pos_t_err;
        logic                is_charged;
        logic [15:0]         particle_pt;
        logic [TAG_BITS-1:0] collection_tag;
    } t_in;

    typedef struct packed {
        logic                is_pileup;
        logic                export_flag;
        logic [TAG_BITS-1:0] out_tag;
    } t_out;

    typedef struct packed {
        logic  busy;
        logic  mul_en;
        t_step step;
        logic  sum_en;
        logic  fin_en;
    } t_ctrl;

endpackage

// ===== rtl/core/vtpt_mul.sv =====
// Shared 32 by 32 unsigned multiplier of the tagger datapath.
module vtpt_mul (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    assign o_p = {32'b0, i_a} * {32'b0, i_b};

endmodule

// ===== rtl/core/vtpt_ctrl.sv =====
// Sequencer that steps the shared multiplier through one particle test.
module vtpt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_out_free,
    output vtpt_pkg::t_ctrl o_ctrl
);
    import vtpt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_SUM  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_step  r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MUL;
                    n_step  = STEP_DZ2;
                end
            end
            S_MUL: begin
                if (r_step == STEP_NR) begin
                    n_state = S_SUM;
                end else begin
                    n_step = t_step'(r_step + 4'd1);
                end
            end
            S_SUM: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_DZ2;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_ctrl.busy   = (r_state != S_IDLE);
    assign o_ctrl.mul_en = (r_state == S_MUL);
    assign o_ctrl.step   = r_step;
    assign o_ctrl.sum_en = (r_state == S_SUM);
    assign o_ctrl.fin_en = (r_state == S_FIN) && i_out_free;

endmodule

// ===== rtl/core/vertex_timing_pileup_tagger_unit.sv =====
// Top level of the vertex timing pile-up tagger: vertex state, config and datapath.
//
// Start and vertex transactions are taken without a stall and give no result.
// A particle transaction occupies the block for twelve products on the single
// shared 32 by 32 multiplier, a step that adds the partial terms and a step that
// compares and loads the output register, and the input stalls during that time.
// The input is taken again while a result still waits at the output, and a new
// result waits for the output register to free up.
module vertex_timing_pileup_tagger_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  vtpt_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output vtpt_pkg::t_out  o_out_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data
);
    import vtpt_pkg::*;

    t_ctrl w_ctrl;
    logic  w_accept;
    logic  w_start;
    logic  w_out_free;

    logic [9:0]  r_lim_c;
    logic [9:0]  r_lim_n;
    logic [15:0] r_pt_min;

    logic [31:0]        r_best;
    logic signed [15:0] r_vz;
    logic [15:0]        r_vz_err;
    logic signed [15:0] r_vt;
    logic [15:0]        r_vt_err;

    logic [15:0]         r_dz, r_dt;
    logic                r_chg;
    logic [15:0]         r_pt;
    logic [TAG_BITS-1:0] r_tag;

    logic [31:0] r_dz2, r_dt2, r_ez2, r_et2;
    logic [19:0] r_lc2, r_ln2;
    logic [63:0] r_p1, r_p2, r_e;
    logic [51:0] r_q0, r_q1, r_nr;
    logic [64:0] r_lhs;
    logic [83:0] r_rhs;

    logic        r_out_valid;
    t_out        r_out;

    logic signed [16:0] w_dz_s, w_dt_s;
    logic [16:0]        w_dz_neg, w_dt_neg;
    logic [15:0]        w_dz, w_dt;
    logic [31:0]        w_a, w_b;
    logic [63:0]        w_prod;
    logic               w_kept_c, w_kept_n, w_kept;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_start    = w_accept && (i_in_data.action == ACT_PARTICLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = w_ctrl.busy;

    vtpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_c  <= RST_CHARGED_LIMIT;
            r_lim_n  <= RST_NEUTRAL_LIMIT;
            r_pt_min <= RST_PT_MINIMUM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHARGED_LIMIT: r_lim_c  <= i_cfg_data[9:0];
                CFG_NEUTRAL_LIMIT: r_lim_n  <= i_cfg_data[9:0];
                CFG_PT_MINIMUM:    r_pt_min <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best   <= '0;
            r_vz     <= '0;
            r_vz_err <= '0;
            r_vt     <= '0;
            r_vt_err <= '0;
        end else if (w_accept) begin
            if (i_in_data.action == ACT_START) begin
                r_best   <= '0;
                r_vz     <= '0;
                r_vz_err <= '0;
                r_vt     <= '0;
                r_vt_err <= '0;
            end else if (i_in_data.action == ACT_VERTEX && i_in_data.sum_pt_sq > r_best) begin
                r_best   <= i_in_data.sum_pt_sq;
                r_vz     <= i_in_data.pos_z;
                r_vz_err <= i_in_data.pos_z_err;
                r_vt     <= i_in_data.pos_t;
                r_vt_err <= i_in_data.pos_t_err;
            end
        end
    end

    assign w_dz_s   = {r_vz[15], r_vz} - {i_in_data.pos_z[15], i_in_data.pos_z};
    assign w_dt_s   = {r_vt[15], r_vt} - {i_in_data.pos_t[15], i_in_data.pos_t};
    assign w_dz_neg = -w_dz_s;
    assign w_dt_neg = -w_dt_s;
    assign w_dz     = w_dz_s[16] ? w_dz_neg[15:0] : w_dz_s[15:0];
    assign w_dt     = w_dt_s[16] ? w_dt_neg[15:0] : w_dt_s[15:0];

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_dz  <= w_dz;
            r_dt  <= w_dt;
            r_chg <= i_in_data.is_charged;
            r_pt  <= i_in_data.particle_pt;
            r_tag <= i_in_data.collection_tag;
        end
    end

    always_comb begin
        unique case (w_ctrl.step)
            STEP_DZ2: begin
                w_a = {16'b0, r_dz};
                w_b = {16'b0, r_dz};
            end
            STEP_DT2: begin
                w_a = {16'b0, r_dt};
                w_b = {16'b0, r_dt};
            end
            STEP_EZ2: begin
                w_a = {16'b0, r_vz_err};
                w_b = {16'b0, r_vz_err};
            end
            STEP_ET2: begin
                w_a = {16'b0, r_vt_err};
                w_b = {16'b0, r_vt_err};
            end
            STEP_LC2: begin
                w_a = {22'b0, r_lim_c};
                w_b = {22'b0, r_lim_c};
            end
            STEP_LN2: begin
                w_a = {22'b0, r_lim_n};
                w_b = {22'b0, r_lim_n};
            end
            STEP_P1: begin
                w_a = r_dz2;
                w_b = r_et2;
            end
            STEP_P2: begin
                w_a = r_dt2;
                w_b = r_ez2;
            end
            STEP_E: begin
                w_a = r_ez2;
                w_b = r_et2;
            end
            STEP_Q0: begin
                w_a = r_e[31:0];
                w_b = {12'b0, r_lc2};
            end
            STEP_Q1: begin
                w_a = r_e[63:32];
                w_b = {12'b0, r_lc2};
            end
            STEP_NR: begin
                w_a = {12'b0, r_ln2};
                w_b = r_et2;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    vtpt_mul u_mul (
        .i_a (w_a),
        .i_b (w_b),
        .o_p (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (w_ctrl.mul_en) begin
            unique case (w_ctrl.step)
                STEP_DZ2: r_dz2 <= w_prod[31:0];
                STEP_DT2: r_dt2 <= w_prod[31:0];
                STEP_EZ2: r_ez2 <= w_prod[31:0];
                STEP_ET2: r_et2 <= w_prod[31:0];
                STEP_LC2: r_lc2 <= w_prod[19:0];
                STEP_LN2: r_ln2 <= w_prod[19:0];
                STEP_P1:  r_p1  <= w_prod;
                STEP_P2:  r_p2  <= w_prod;
                STEP_E:   r_e   <= w_prod;
                STEP_Q0:  r_q0  <= w_prod[51:0];
                STEP_Q1:  r_q1  <= w_prod[51:0];
                STEP_NR:  r_nr  <= w_prod[51:0];
                default: begin
                end
            endcase
        end
        if (w_ctrl.sum_en) begin
            r_lhs <= {1'b0, r_p1} + {1'b0, r_p2};
            r_rhs <= {32'b0, r_q0} + {r_q1, 32'b0};
        end
    end

    assign w_kept_c = {11'b0, r_lhs, 8'b0} < r_rhs;
    assign w_kept_n = {12'b0, r_dt2, 8'b0} < r_nr;
    assign w_kept   = r_chg ? w_kept_c : w_kept_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.fin_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.fin_en) begin
            r_out.is_pileup   <= !w_kept;
            r_out.export_flag <= w_kept && (r_pt > r_pt_min);
            r_out.out_tag     <= r_tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
